[hw/rtl/fau_pkg.sv]
// Fraction arithmetic unit: shared constants, operation codes and the
// command and status records between controller and datapath. No dependencies.
`default_nettype none

package fau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int SHIFT_W    = $clog2(DATA_WIDTH);
  localparam int STEP_W     = $clog2(DATA_WIDTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;
  typedef logic [2:0]                   mode_t;
  typedef logic [1:0]                   mul_sel_t;

  localparam mode_t MODE_ADD        = 3'd0;
  localparam mode_t MODE_INT_PLUS   = 3'd1;
  localparam mode_t MODE_INT_MINUS  = 3'd2;
  localparam mode_t MODE_FRAC_MINUS = 3'd3;
  localparam mode_t MODE_NEGATE     = 3'd4;
  localparam mode_t MODE_INC        = 3'd5;
  localparam mode_t MODE_DEC        = 3'd6;
  localparam mode_t MODE_REDUCE     = 3'd7;

  localparam mul_sel_t MUL_NA_DB = 2'd0;
  localparam mul_sel_t MUL_DA_NB = 2'd1;
  localparam mul_sel_t MUL_DA_DB = 2'd2;
  localparam mul_sel_t MUL_K_DA  = 2'd3;

  typedef struct packed {
    logic     load;
    logic     mul;
    mul_sel_t mul_sel;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  zero_part;
    logic  gcd_done;
    logic  div_done;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/fau_if.sv]
// Fraction arithmetic unit: valid/ready channel interfaces for the operand
// request and the result. Depends on fau_pkg.
`default_nettype none

interface fau_op_if;
  logic                valid;
  logic                ready;
  fau_pkg::mode_t      mode;
  fau_pkg::word_t      num_a;
  fau_pkg::word_t      den_a;
  fau_pkg::word_t      num_b;
  fau_pkg::word_t      den_b;
  fau_pkg::word_t      whole_value;

  modport source (output valid, mode, num_a, den_a, num_b, den_b, whole_value,
                  input ready);
  modport sink   (input valid, mode, num_a, den_a, num_b, den_b, whole_value,
                  output ready);
endinterface

interface fau_res_if;
  logic           valid;
  logic           ready;
  fau_pkg::word_t res_num;
  fau_pkg::word_t res_den;

  modport source (output valid, res_num, res_den, input ready);
  modport sink   (input valid, res_num, res_den, output ready);
endinterface

`default_nettype wire

[hw/rtl/fau_ctrl.sv]
// Fraction arithmetic unit controller: sequences multiplies, gcd and divide
// steps and owns the handshakes. Depends on fau_pkg.
`default_nettype none

module fau_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             op_valid,
  output logic                  op_ready,
  output logic                  res_valid,
  input  wire logic             res_ready,
  input  wire fau_pkg::status_t status,
  output fau_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_GCD   = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]        state, state_next;
  fau_pkg::mul_sel_t mul_step, mul_step_next;

  assign op_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    mul_step_next = mul_step;
    case (state)
      S_IDLE: begin
        if (op_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (status.mode)
          fau_pkg::MODE_ADD: begin
            state_next    = S_MUL;
            mul_step_next = fau_pkg::MUL_NA_DB;
          end
          fau_pkg::MODE_INT_PLUS, fau_pkg::MODE_INT_MINUS,
          fau_pkg::MODE_FRAC_MINUS: begin
            state_next    = S_MUL;
            mul_step_next = fau_pkg::MUL_K_DA;
          end
          fau_pkg::MODE_REDUCE: begin
            state_next = status.zero_part ? S_FIN : S_GCD;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = mul_step;
        if (mul_step == fau_pkg::MUL_DA_DB || mul_step == fau_pkg::MUL_K_DA) begin
          state_next = S_FIN;
        end else begin
          mul_step_next = fau_pkg::mul_sel_t'(mul_step + 2'd1);
        end
      end
      S_GCD: begin
        if (status.gcd_done) begin
          state_next = S_DINIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!res_valid || res_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_step  <= fau_pkg::MUL_NA_DB;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      mul_step <= mul_step_next;
      if (cmd.res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fau_dp.sv]
// Fraction arithmetic unit datapath: operand registers, shared multiplier,
// binary gcd, paired restoring divider and result register. Depends on fau_pkg.
`default_nettype none

module fau_dp (
  input  wire logic           clk,
  input  wire fau_pkg::cmd_t  cmd,
  output fau_pkg::status_t    status,
  input  wire fau_pkg::mode_t mode,
  input  wire fau_pkg::word_t num_a,
  input  wire fau_pkg::word_t den_a,
  input  wire fau_pkg::word_t num_b,
  input  wire fau_pkg::word_t den_b,
  input  wire fau_pkg::word_t whole_value,
  output fau_pkg::word_t      res_num,
  output fau_pkg::word_t      res_den
);

  localparam int W = fau_pkg::DATA_WIDTH;

  function automatic fau_pkg::mag_t mag_of(input fau_pkg::word_t v);
    return v[W-1] ? fau_pkg::mag_t'(-v) : fau_pkg::mag_t'(v);
  endfunction

  fau_pkg::mode_t                   mode_r;
  fau_pkg::word_t                   na, da, nb, db, kw;
  fau_pkg::word_t                   pa, pb, pd;
  fau_pkg::mag_t                    ga, gb, g;
  logic [fau_pkg::SHIFT_W-1:0]      gk;
  logic                             zero_part;
  fau_pkg::mag_t                    qn, qd, rmn, rmd;
  logic [fau_pkg::STEP_W-1:0]       dcnt;

  fau_pkg::mag_t                    mul_a, mul_b, prod;
  fau_pkg::mag_t                    ga_next, gb_next;
  logic [fau_pkg::SHIFT_W-1:0]      gk_next;
  logic [W:0]                       shn, shd;
  logic                             gen, ged;
  fau_pkg::word_t                   rn_next, rd_next;
  fau_pkg::mag_t                    mag_in_n, mag_in_d;

  assign mag_in_n = mag_of(num_a);
  assign mag_in_d = mag_of(den_a);

  always_comb begin
    case (cmd.mul_sel)
      fau_pkg::MUL_NA_DB: begin mul_a = na; mul_b = db; end
      fau_pkg::MUL_DA_NB: begin mul_a = da; mul_b = nb; end
      fau_pkg::MUL_DA_DB: begin mul_a = da; mul_b = db; end
      default:            begin mul_a = kw; mul_b = da; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    ga_next = ga;
    gb_next = gb;
    gk_next = gk;
    if (!ga[0] && !gb[0]) begin
      ga_next = ga >> 1;
      gb_next = gb >> 1;
      gk_next = gk + fau_pkg::SHIFT_W'(1);
    end else if (!ga[0]) begin
      ga_next = ga >> 1;
    end else if (!gb[0]) begin
      gb_next = gb >> 1;
    end else if (ga >= gb) begin
      ga_next = (ga - gb) >> 1;
    end else begin
      gb_next = (gb - ga) >> 1;
    end
  end

  assign shn = {rmn, qn[W-1]};
  assign shd = {rmd, qd[W-1]};
  assign gen = (shn >= {1'b0, g});
  assign ged = (shd >= {1'b0, g});

  always_comb begin
    rd_next = da;
    case (mode_r)
      fau_pkg::MODE_ADD: begin
        rn_next = pa + pb;
        rd_next = pd;
      end
      fau_pkg::MODE_INT_PLUS:   rn_next = na + pa;
      fau_pkg::MODE_INT_MINUS:  rn_next = pa - na;
      fau_pkg::MODE_FRAC_MINUS: rn_next = na - pa;
      fau_pkg::MODE_NEGATE:     rn_next = -na;
      fau_pkg::MODE_INC:        rn_next = na + da;
      fau_pkg::MODE_DEC:        rn_next = na - da;
      fau_pkg::MODE_REDUCE: begin
        if (zero_part) begin
          rn_next = na;
        end else begin
          rn_next = na[W-1] ? fau_pkg::word_t'(-qn) : fau_pkg::word_t'(qn);
          rd_next = da[W-1] ? fau_pkg::word_t'(-qd) : fau_pkg::word_t'(qd);
        end
      end
      default: rn_next = na;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode;
      na        <= num_a;
      da        <= den_a;
      nb        <= num_b;
      db        <= den_b;
      kw        <= whole_value;
      ga        <= mag_in_n;
      gb        <= mag_in_d;
      gk        <= '0;
      zero_part <= (mag_in_n == '0) || (mag_in_d == '0);
    end
    if (cmd.mul) begin
      case (cmd.mul_sel)
        fau_pkg::MUL_DA_NB: pb <= prod;
        fau_pkg::MUL_DA_DB: pd <= prod;
        default:            pa <= prod;
      endcase
    end
    if (cmd.gcd_step) begin
      ga <= ga_next;
      gb <= gb_next;
      gk <= gk_next;
    end
    if (cmd.div_init) begin
      g    <= (ga | gb) << gk;
      qn   <= mag_of(na);
      qd   <= mag_of(da);
      rmn  <= '0;
      rmd  <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      qn   <= {qn[W-2:0], gen};
      qd   <= {qd[W-2:0], ged};
      rmn  <= gen ? fau_pkg::mag_t'(shn - {1'b0, g}) : shn[W-1:0];
      rmd  <= ged ? fau_pkg::mag_t'(shd - {1'b0, g}) : shd[W-1:0];
      dcnt <= dcnt + fau_pkg::STEP_W'(1);
    end
    if (cmd.res_load) begin
      res_num <= rn_next;
      res_den <= rd_next;
    end
  end

  assign status.mode      = mode_r;
  assign status.zero_part = zero_part;
  assign status.gcd_done  = (ga == '0) || (gb == '0);
  assign status.div_done  = (dcnt == fau_pkg::STEP_W'(W));

endmodule

`default_nettype wire

[hw/rtl/fraction_arithmetic_unit_top.sv]
// Fraction arithmetic unit top level: joins controller and datapath to the
// operand and result channels. Depends on fau_pkg, fau_if, fau_ctrl, fau_dp.
//
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted. Negate, increment and
// decrement use no multiplier pass; the integer plus/minus modes and fraction
// minus use one pass through the shared 32x32 multiplier and add uses three
// multiplier passes. Reduce skips gcd and divider when either part is zero.
// Otherwise it runs S binary gcd steps (at most 2*W, one step per cycle) and
// then the paired restoring divider of length W = 32, which produces both
// quotients at one bit per cycle.
`default_nettype none

module fraction_arithmetic_unit_top (
  input wire logic clk,
  input wire logic rst,
  fau_op_if.sink   operands,
  fau_res_if.source results
);

  fau_pkg::cmd_t    cmd;
  fau_pkg::status_t status;
  logic             res_valid;
  logic             op_ready;

  fau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (operands.valid),
    .op_ready  (op_ready),
    .res_valid (res_valid),
    .res_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fau_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .mode        (operands.mode),
    .num_a       (operands.num_a),
    .den_a       (operands.den_a),
    .num_b       (operands.num_b),
    .den_b       (operands.den_b),
    .whole_value (operands.whole_value),
    .res_num     (results.res_num),
    .res_den     (results.res_den)
  );

  assign operands.ready = op_ready;
  assign results.valid  = res_valid;

endmodule

`default_nettype wire

[hw/rtl/fau_checker.sv]
// Fraction arithmetic unit port checker and its bind onto the top level.
// Depends on fau_pkg and fraction_arithmetic_unit_top.
`default_nettype none

module fau_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           op_valid,
  input wire logic           op_ready,
  input wire fau_pkg::mode_t op_mode,
  input wire fau_pkg::word_t op_num_a,
  input wire fau_pkg::word_t op_den_a,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire fau_pkg::word_t res_num,
  input wire fau_pkg::word_t res_den
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready) |=> !op_ready)
    else $error("second request taken while one is in flight");

  a_negate_result: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready && op_mode == fau_pkg::MODE_NEGATE && !res_valid)
    |=> ##2 (res_valid && res_num == -$past(op_num_a, 3)
             && res_den == $past(op_den_a, 3)))
    else $error("negate result wrong or late");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_num) && $stable(res_den)))
    else $error("stalled result changed");

endmodule

bind fraction_arithmetic_unit_top fau_checker u_fau_checker (
  .clk       (clk),
  .rst       (rst),
  .op_valid  (operands.valid),
  .op_ready  (operands.ready),
  .op_mode   (operands.mode),
  .op_num_a  (operands.num_a),
  .op_den_a  (operands.den_a),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_num   (results.res_num),
  .res_den   (results.res_den)
);

`default_nettype wire
